// ----- rtl/core/kalman_position_update_2state_core_assert.svh -----
// assertion macros for the kalman position update core
`ifndef KALMAN_POSITION_UPDATE_2STATE_CORE_ASSERT_SVH
`define KALMAN_POSITION_UPDATE_2STATE_CORE_ASSERT_SVH

// same-cycle implication, checked on clk, off while rst_n is low
`define KPU2_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, off while rst_n is low
`define KPU2_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/kpu2_pkg.sv -----
// shared widths, constants and types of the kalman position update core
`timescale 1ns / 1ps
package kpu2_pkg;

  localparam int FRAC_BITS = 16;
  localparam int FW        = 32;                  // field width
  localparam int CFG_W     = FW - 1;              // noise register width
  localparam int IN_W      = 7 * FW;
  localparam int OUT_W     = 6 * FW;
  localparam int NW        = FW + FRAC_BITS + 2;  // divider numerator 2n + d
  localparam int QB        = FW + 1;              // quotient bits
  localparam int DW        = FW + 1;              // divisor 2s
  localparam int RW        = DW + 1;              // partial remainder
  localparam int PW        = 2 * FW + 1;          // product width
  localparam int RDW       = PW - FRAC_BITS;      // rounded product width
  localparam int SUMW      = RDW + 1;             // final sum width

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1) << FRAC_BITS;
  localparam logic [PW-1:0]    HALF_POS  = PW'(1) << (FRAC_BITS - 1);
  localparam logic [PW-1:0]    HALF_NEG  = HALF_POS - PW'(1);

  typedef struct packed {
    logic signed [FW-1:0] pos;
    logic signed [FW-1:0] vel;
    logic signed [FW-1:0] cpp;
    logic signed [FW-1:0] cpv;
    logic signed [FW-1:0] cvp;
    logic signed [FW-1:0] cvv;
    logic signed [FW:0]   res;   // residual z - pos
    logic                 bad;
  } data_t;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [NW-1:0] num;
    logic [QB-1:0] quo;
    logic          ovf;
    logic          neg;
  } lane_t;

endpackage

// ----- rtl/core/kalman_position_update_2state_core.sv -----
// two-state kalman measurement update, fully pipelined
//
//  channel  dir  signals                          contents
//  in       in   in_tvalid/in_tready/in_tdata     pos vel cov_pp cov_pv cov_vp cov_vv meas_pos
//  out      out  out_tvalid/out_tready/out_tdata  new_pos new_vel new_cov_pp .. new_cov_vv
//                out_tuser                        bad_innovation
//  cfg      in   cfg_wr_en/cfg_wr_data            meas_noise
//
//  one transaction per cycle in and out while out_tready does not stall the pipeline; the
//  restoring gain divider retires one quotient bit per stage
//  all stages advance together when the output register is empty or being taken
//  rst_n is synchronous, clears the valid bits and loads meas_noise with 1.0
//  a stall on out_tready freezes every stage, nothing is dropped or repeated
`timescale 1ns / 1ps
`include "kalman_position_update_2state_core_assert.svh"
module kalman_position_update_2state_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [kpu2_pkg::CFG_W-1:0]    cfg_wr_data,   // meas_noise
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // pos, vel, cov_pp, cov_pv, cov_vp, cov_vv, meas_pos (lowest first)
  input  logic [kpu2_pkg::IN_W-1:0]     in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // new_pos, new_vel, new_cov_pp, new_cov_pv, new_cov_vp, new_cov_vv (lowest first)
  output logic [kpu2_pkg::OUT_W-1:0]    out_tdata,
  // bad_innovation
  output logic                          out_tuser
);
  import kpu2_pkg::*;

  // one quotient bit of the restoring division
  function automatic lane_t div_step(lane_t l, logic [DW-1:0] den, logic b);
    lane_t         o;
    logic [RW-1:0] t;
    logic          ge;
    o  = l;
    t  = {l.rem[RW-2:0], b};
    ge = t >= RW'(den);
    o.rem = ge ? t - RW'(den) : t;
    o.quo = {l.quo[QB-2:0], ge};
    return o;
  endfunction

  // gain saturation and sign
  function automatic logic signed [FW-1:0] gain_sat(lane_t l);
    logic signed [FW-1:0] k;
    if (l.neg) begin
      if (l.ovf || l.quo > (QB'(1) << (FW - 1))) k = {1'b1, {(FW-1){1'b0}}};
      else                                       k = -l.quo[FW-1:0];
    end else begin
      if (l.ovf || l.quo > ((QB'(1) << (FW - 1)) - QB'(1))) k = {1'b0, {(FW-1){1'b1}}};
      else                                                  k = l.quo[FW-1:0];
    end
    return k;
  endfunction

  // round to nearest, ties away from zero, drop the fraction bits
  function automatic logic signed [RDW-1:0] rnd(logic signed [PW-1:0] v);
    logic [PW-1:0] t;
    t = v + (v[PW-1] ? HALF_NEG : HALF_POS);
    return t[PW-1:FRAC_BITS];
  endfunction

  function automatic logic signed [FW-1:0] sat(logic signed [SUMW-1:0] v);
    logic signed [FW-1:0] o;
    if (&v[SUMW-1:FW-1] || ~|v[SUMW-1:FW-1]) o = v[FW-1:0];
    else o = v[SUMW-1] ? {1'b1, {(FW-1){1'b0}}} : {1'b0, {(FW-1){1'b1}}};
    return o;
  endfunction

  function automatic logic signed [SUMW-1:0] ext(logic signed [FW-1:0] a);
    return SUMW'(a);
  endfunction

  function automatic logic signed [SUMW-1:0] exr(logic signed [RDW-1:0] a);
    return SUMW'(a);
  endfunction

  logic                 adv;
  logic [CFG_W-1:0]     meas_noise_r;

  // stage a: sum, residual, magnitudes
  logic                 sa_vld_r;
  data_t                sa_dat_r, sa_dat_nxt;
  logic [FW-1:0]        sa_s_r;
  logic [FW-1:0]        sa_mag0_r, sa_mag1_r;
  logic                 sa_neg0_r, sa_neg1_r;
  logic signed [FW:0]   s_full;

  // divider stages
  logic                 dv_vld_r [0:QB];
  data_t                dv_dat_r [0:QB];
  logic [DW-1:0]        dv_den_r [0:QB];
  lane_t                dv_l0_r  [0:QB];
  lane_t                dv_l1_r  [0:QB];
  lane_t                l0_nxt, l1_nxt;
  logic [DW-1:0]        den_nxt;

  // gain, products, rounding, output
  logic                 g_vld_r;
  data_t                g_dat_r;
  logic signed [FW-1:0] g_k0_r, g_k1_r;
  logic                 m_vld_r;
  data_t                m_dat_r;
  logic signed [PW-1:0] m_p_r [0:5];
  logic                 r_vld_r;
  data_t                r_dat_r;
  logic signed [RDW-1:0] r_rnd_r [0:5];
  logic                 o_vld_r;
  logic signed [FW-1:0] o_f_r [0:5];
  logic                 o_bad_r;

  assign adv       = !o_vld_r || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meas_noise_r <= CFG_RESET;
    end else if (cfg_wr_en) begin
      meas_noise_r <= cfg_wr_data;
    end
  end

  // stage a
  always_comb begin
    sa_dat_nxt.pos = in_tdata[0*FW +: FW];
    sa_dat_nxt.vel = in_tdata[1*FW +: FW];
    sa_dat_nxt.cpp = in_tdata[2*FW +: FW];
    sa_dat_nxt.cpv = in_tdata[3*FW +: FW];
    sa_dat_nxt.cvp = in_tdata[4*FW +: FW];
    sa_dat_nxt.cvv = in_tdata[5*FW +: FW];
    sa_dat_nxt.res = (FW+1)'($signed(in_tdata[6*FW +: FW])) - (FW+1)'(sa_dat_nxt.pos);
    s_full         = (FW+1)'(sa_dat_nxt.cpp) + $signed({2'b00, meas_noise_r});
    sa_dat_nxt.bad = s_full[FW] || (s_full == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_vld_r <= 1'b0;
    end else if (adv) begin
      sa_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sa_dat_r  <= sa_dat_nxt;
      sa_s_r    <= s_full[FW-1:0];
      sa_neg0_r <= sa_dat_nxt.cpp[FW-1];
      sa_neg1_r <= sa_dat_nxt.cvp[FW-1];
      sa_mag0_r <= sa_dat_nxt.cpp[FW-1] ? -sa_dat_nxt.cpp : sa_dat_nxt.cpp;
      sa_mag1_r <= sa_dat_nxt.cvp[FW-1] ? -sa_dat_nxt.cvp : sa_dat_nxt.cvp;
    end
  end

  // divider setup: numerator 2*|p|*2^f + s over divisor 2s
  always_comb begin
    den_nxt    = {sa_s_r, 1'b0};
    l0_nxt.num = NW'({sa_mag0_r, {(FRAC_BITS+1){1'b0}}}) + NW'(sa_s_r);
    l1_nxt.num = NW'({sa_mag1_r, {(FRAC_BITS+1){1'b0}}}) + NW'(sa_s_r);
    l0_nxt.rem = RW'(l0_nxt.num[NW-1:QB]);
    l1_nxt.rem = RW'(l1_nxt.num[NW-1:QB]);
    l0_nxt.ovf = l0_nxt.rem >= RW'(den_nxt);
    l1_nxt.ovf = l1_nxt.rem >= RW'(den_nxt);
    l0_nxt.quo = '0;
    l1_nxt.quo = '0;
    l0_nxt.neg = sa_neg0_r;
    l1_nxt.neg = sa_neg1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else if (adv) begin
      dv_vld_r[0] <= sa_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_dat_r[0] <= sa_dat_r;
      dv_den_r[0] <= den_nxt;
      dv_l0_r[0]  <= l0_nxt;
      dv_l1_r[0]  <= l1_nxt;
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[k] <= 1'b0;
      end else if (adv) begin
        dv_vld_r[k] <= dv_vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_dat_r[k] <= dv_dat_r[k-1];
        dv_den_r[k] <= dv_den_r[k-1];
        dv_l0_r[k]  <= div_step(dv_l0_r[k-1], dv_den_r[k-1], dv_l0_r[k-1].num[QB-k]);
        dv_l1_r[k]  <= div_step(dv_l1_r[k-1], dv_den_r[k-1], dv_l1_r[k-1].num[QB-k]);
      end
    end
  end

  // gain, products, rounding, final sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r <= 1'b0;
      m_vld_r <= 1'b0;
      r_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else if (adv) begin
      g_vld_r <= dv_vld_r[QB];
      m_vld_r <= g_vld_r;
      r_vld_r <= m_vld_r;
      o_vld_r <= r_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_dat_r <= dv_dat_r[QB];
      g_k0_r  <= gain_sat(dv_l0_r[QB]);
      g_k1_r  <= gain_sat(dv_l1_r[QB]);

      m_dat_r  <= g_dat_r;
      m_p_r[0] <= PW'(g_k0_r) * PW'(g_dat_r.res);
      m_p_r[1] <= PW'(g_k1_r) * PW'(g_dat_r.res);
      m_p_r[2] <= PW'(g_k0_r) * PW'(g_dat_r.cpp);
      m_p_r[3] <= PW'(g_k0_r) * PW'(g_dat_r.cpv);
      m_p_r[4] <= PW'(g_k1_r) * PW'(g_dat_r.cpp);
      m_p_r[5] <= PW'(g_k1_r) * PW'(g_dat_r.cpv);

      r_dat_r <= m_dat_r;
      for (int i = 0; i < 6; i++) begin
        r_rnd_r[i] <= rnd(m_p_r[i]);
      end

      o_bad_r <= r_dat_r.bad;
      if (r_dat_r.bad) begin
        // non-positive innovation: pass the input through
        o_f_r[0] <= r_dat_r.pos;
        o_f_r[1] <= r_dat_r.vel;
        o_f_r[2] <= r_dat_r.cpp;
        o_f_r[3] <= r_dat_r.cpv;
        o_f_r[4] <= r_dat_r.cvp;
        o_f_r[5] <= r_dat_r.cvv;
      end else begin
        o_f_r[0] <= sat(ext(r_dat_r.pos) + exr(r_rnd_r[0]));
        o_f_r[1] <= sat(ext(r_dat_r.vel) + exr(r_rnd_r[1]));
        o_f_r[2] <= sat(ext(r_dat_r.cpp) - exr(r_rnd_r[2]));
        o_f_r[3] <= sat(ext(r_dat_r.cpv) - exr(r_rnd_r[3]));
        o_f_r[4] <= sat(ext(r_dat_r.cvp) - exr(r_rnd_r[4]));
        o_f_r[5] <= sat(ext(r_dat_r.cvv) - exr(r_rnd_r[5]));
      end
    end
  end

  assign out_tvalid = o_vld_r;
  assign out_tdata  = {o_f_r[5], o_f_r[4], o_f_r[3], o_f_r[2], o_f_r[1], o_f_r[0]};
  assign out_tuser  = o_bad_r;

  `KPU2_ASSERT_NXT(a_in_enters, in_tvalid && in_tready, sa_vld_r, "accepted transaction lost at stage a")
  `KPU2_ASSERT_IMP(a_rem_bound, dv_vld_r[QB] && !dv_dat_r[QB].bad && !dv_l0_r[QB].ovf, dv_l0_r[QB].rem < RW'(dv_den_r[QB]), "divider remainder out of range")
  `KPU2_ASSERT_NXT(a_stall_hold, r_vld_r && !adv, r_vld_r && $stable(r_rnd_r[0]), "rounding stage moved during stall")

endmodule
